// ===== rtl/core/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_DATA       = 2'd0;
    localparam logic [1:0] OP_DATA_FLUSH = 2'd1;
    localparam logic [1:0] OP_FLUSH      = 2'd2;

    localparam logic [15:0] REPL_UNIT = 16'hFFFD;

    // Continuation bytes match 10xxxxxx.
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // Depth of the result queue, in code units.
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        last;
    } t_out_item;

    // Sequence tracker states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,  // no open sequence
        ST_TWO_2   = 8'b0000_0010,  // two-byte form, waiting for byte 2
        ST_THREE_2 = 8'b0000_0100,  // three-byte form, waiting for byte 2
        ST_THREE_3 = 8'b0000_1000,  // three-byte form, waiting for byte 3
        ST_FOUR_2  = 8'b0001_0000,  // four-byte form, waiting for byte 2
        ST_FOUR_3  = 8'b0010_0000,  // four-byte form, waiting for byte 3
        ST_FOUR_4  = 8'b0100_0000,  // four-byte form, waiting for byte 4
        ST_SKIP    = 8'b1000_0000   // skipping a five- or six-byte form
    } t_seq_state;

endpackage

`default_nettype wire

// ===== rtl/core/utf8_to_utf16_decoder.sv =====
`default_nettype none

// Channel | Direction | Handshake                         | Payload
// in      | input     | i_in_valid  / o_in_stall          | i_in_data  (op, byte_in)
// out     | output    | o_out_valid / i_out_stall         | o_out_data (code_unit, replaced, last)
//
// One input item is accepted per clock while at most two code units are queued;
// its decode happens in the cycle of acceptance and its units enter the result queue.
// Code units leave the queue one per cycle while the output is not stalled, so an item
// that yields a surrogate pair (or a replacement plus a unit) fills two queue entries.
// Reset is synchronous; there is no clearing pass.
// A stall on the output holds the queue head; the input stalls once three or more
// units are waiting, which depends on registered state only.

module utf8_to_utf16_decoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_in_valid,
    input  wire u8u16_pkg::t_in_item i_in_data,
    output logic                  o_in_stall,

    output logic                  o_out_valid,
    output u8u16_pkg::t_out_item  o_out_data,
    input  wire                   i_out_stall
);

    import u8u16_pkg::*;

    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    // Decoder state.
    t_seq_state r_state, n_state;
    logic [7:0] r_lead, n_lead;
    logic [7:0] r_second, n_second;
    logic [7:0] r_third, n_third;
    logic [2:0] r_skip, n_skip;

    // Result queue: entry zero is the head that the output shows.
    t_out_item       r_q [QUEUE_DEPTH];
    t_out_item       n_q [QUEUE_DEPTH];
    logic [CntW-1:0] r_count, n_count;

    logic in_accept;
    logic out_pop;

    assign o_in_stall  = (r_count > CntW'(QUEUE_DEPTH - 2));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_q[0];
    assign out_pop     = o_out_valid && !i_out_stall;

    //------------------------------------------------------------------
    // Lead byte analysis: what the byte does when it opens a sequence.
    //------------------------------------------------------------------
    logic [7:0]  b;
    logic [3:0]  b_hi;
    logic [3:0]  b_lo;
    logic        b_cont;
    logic        sb_emit;
    logic [15:0] sb_unit;
    logic        sb_rep;
    t_seq_state  sb_state;
    logic        sb_lead_wr;
    logic        sb_skip_wr;
    logic [2:0]  sb_skip;

    assign b      = i_in_data.byte_in;
    assign b_hi   = b[7:4];
    assign b_lo   = b[3:0];
    assign b_cont = ((b & CONT_MASK) == CONT_TAG);

    always_comb begin
        sb_emit    = 1'b0;
        sb_unit    = REPL_UNIT;
        sb_rep     = 1'b1;
        sb_state   = ST_IDLE;
        sb_lead_wr = 1'b0;
        sb_skip_wr = 1'b0;
        sb_skip    = 3'd4;
        if (b_hi == 4'hC || b_hi == 4'hD) begin
            sb_lead_wr = 1'b1;
            sb_state   = ST_TWO_2;
        end else if (b_hi == 4'hE) begin
            sb_lead_wr = 1'b1;
            sb_state   = ST_THREE_2;
        end else if (b_hi == 4'hF) begin
            if (b_lo < 4'h8) begin
                sb_lead_wr = 1'b1;
                sb_state   = ST_FOUR_2;
            end else if (b_lo < 4'hE) begin
                // Five-byte forms skip four continuations, six-byte forms five.
                sb_skip_wr = 1'b1;
                sb_skip    = (b_lo >= 4'hC) ? 3'd5 : 3'd4;
                sb_state   = ST_SKIP;
            end else begin
                sb_emit = 1'b1;
            end
        end else if (b[7]) begin
            // A continuation byte with no sequence open.
            sb_emit = 1'b1;
        end else begin
            sb_emit = 1'b1;
            sb_unit = {8'h00, b};
            sb_rep  = 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Sequence decode for one accepted item.
    //------------------------------------------------------------------
    logic        data_taken;
    logic        flush;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;
    logic [20:0] w4;
    logic        v3_bad;
    logic        v4_ok;
    logic [1:0]  d_cnt;
    logic [15:0] d_unit0, d_unit1;
    logic        d_rep0, d_rep1;
    t_seq_state  d_state;
    logic        f_emit;
    logic [1:0]  e_cnt;
    t_out_item   e_item0, e_item1;

    assign data_taken = (i_in_data.op == OP_DATA) || (i_in_data.op == OP_DATA_FLUSH);
    assign flush      = (i_in_data.op != OP_DATA);

    assign v2 = {r_lead[4:0], b[5:0]};
    assign v3 = {r_lead[3:0], r_second[5:0], b[5:0]};
    assign v4 = {r_lead[2:0], r_second[5:0], r_third[5:0], b[5:0]};
    assign w4 = v4 - 21'h010000;

    assign v3_bad = (v3 < 16'h0800) || ((v3 >= 16'hD800) && (v3 <= 16'hDFFF))
                 || (v3 >= 16'hFFFE);
    assign v4_ok  = (v4 > 21'h00FFFF) && (v4 < 21'h10FFFE)
                 && (v4 != 21'h01FFFE) && (v4 != 21'h01FFFF);

    always_comb begin
        d_cnt    = 2'd0;
        d_unit0  = REPL_UNIT;
        d_rep0   = 1'b1;
        d_unit1  = REPL_UNIT;
        d_rep1   = 1'b1;
        d_state  = r_state;
        n_lead   = r_lead;
        n_second = r_second;
        n_third  = r_third;
        n_skip   = r_skip;

        if (in_accept && data_taken) begin
            if (r_state != ST_IDLE && !b_cont) begin
                // A broken sequence: replace it, then decode this byte afresh.
                d_cnt   = sb_emit ? 2'd2 : 2'd1;
                d_unit1 = sb_unit;
                d_rep1  = sb_rep;
                d_state = sb_state;
                if (sb_lead_wr) begin
                    n_lead = b;
                end
                if (sb_skip_wr) begin
                    n_skip = sb_skip;
                end
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        d_cnt   = {1'b0, sb_emit};
                        d_unit0 = sb_unit;
                        d_rep0  = sb_rep;
                        d_state = sb_state;
                        if (sb_lead_wr) begin
                            n_lead = b;
                        end
                        if (sb_skip_wr) begin
                            n_skip = sb_skip;
                        end
                    end
                    ST_TWO_2: begin
                        d_cnt   = 2'd1;
                        d_state = ST_IDLE;
                        if (v2 >= 11'h080) begin
                            d_unit0 = {5'd0, v2};
                            d_rep0  = 1'b0;
                        end
                    end
                    ST_THREE_2: begin
                        n_second = b;
                        d_state  = ST_THREE_3;
                    end
                    ST_THREE_3: begin
                        d_cnt   = 2'd1;
                        d_state = ST_IDLE;
                        if (!v3_bad) begin
                            d_unit0 = v3;
                            d_rep0  = 1'b0;
                        end
                    end
                    ST_FOUR_2: begin
                        n_second = b;
                        d_state  = ST_FOUR_3;
                    end
                    ST_FOUR_3: begin
                        n_third = b;
                        d_state = ST_FOUR_4;
                    end
                    ST_FOUR_4: begin
                        d_state = ST_IDLE;
                        if (v4_ok) begin
                            // Surrogate pair, high half first.
                            d_cnt   = 2'd2;
                            d_unit0 = {6'b110110, w4[19:10]};
                            d_rep0  = 1'b0;
                            d_unit1 = {6'b110111, w4[9:0]};
                            d_rep1  = 1'b0;
                        end else begin
                            d_cnt = 2'd1;
                        end
                    end
                    ST_SKIP: begin
                        if (r_skip <= 3'd1) begin
                            d_cnt   = 2'd1;
                            d_state = ST_IDLE;
                        end else begin
                            n_skip = r_skip - 3'd1;
                        end
                    end
                    default: begin
                        d_state = ST_IDLE;
                    end
                endcase
            end
        end
    end

    // A flush closes any sequence still open with one replacement unit.
    assign f_emit = in_accept && flush && (d_state != ST_IDLE);

    always_comb begin
        e_cnt   = d_cnt;
        n_state = in_accept ? (f_emit ? ST_IDLE : d_state) : r_state;

        e_item0.code_unit = d_unit0;
        e_item0.replaced  = d_rep0;
        e_item0.last      = 1'b0;
        e_item1.code_unit = d_unit1;
        e_item1.replaced  = d_rep1;
        e_item1.last      = 1'b0;

        if (f_emit && d_cnt == 2'd0) begin
            e_item0.code_unit = REPL_UNIT;
            e_item0.replaced  = 1'b1;
            e_cnt             = 2'd1;
        end else if (f_emit && d_cnt == 2'd1) begin
            e_item1.code_unit = REPL_UNIT;
            e_item1.replaced  = 1'b1;
            e_cnt             = 2'd2;
        end

        // Mark the final unit that this item produces.
        e_item0.last = (e_cnt == 2'd1);
        e_item1.last = (e_cnt == 2'd2);
    end

    //------------------------------------------------------------------
    // Result queue update: pop shifts toward the head, new units land
    // right behind whatever remains.
    //------------------------------------------------------------------
    logic [CntW-1:0] base;
    logic [CntW-1:0] base_p1;

    assign base    = r_count - CntW'(out_pop);
    assign base_p1 = base + CntW'(1);

    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (out_pop && k < QUEUE_DEPTH - 1) begin
                n_q[k] = r_q[k + 1];
            end else begin
                n_q[k] = r_q[k];
            end
            if (in_accept && e_cnt != 2'd0 && base == CntW'(k)) begin
                n_q[k] = e_item0;
            end
            if (in_accept && e_cnt == 2'd2 && base_p1 == CntW'(k)) begin
                n_q[k] = e_item1;
            end
        end
        n_count = base + (in_accept ? CntW'(e_cnt) : CntW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_lead   <= '0;
            r_second <= '0;
            r_third  <= '0;
            r_skip   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_lead   <= n_lead;
            r_second <= n_second;
            r_third  <= n_third;
            r_skip   <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/u8u16_checker.sv =====
`default_nettype none

module u8u16_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_out_valid,
    input wire u8u16_pkg::t_out_item o_out_data,
    input wire                   i_out_stall
);

    import u8u16_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // A replacement unit always carries U+FFFD.
    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.replaced |-> o_out_data.code_unit == REPL_UNIT)
        else $error("replacement unit is not U+FFFD");

    // A decoded high surrogate is never the final unit of its item.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.replaced && o_out_data.code_unit[15:10] == 6'b110110
        |-> !o_out_data.last)
        else $error("high surrogate marked last");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_u8u16_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ===== verif/utf8_to_utf16_decoder_test.sv =====
`default_nettype none

module utf8_to_utf16_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    // The fourth op code is not named in the package, but the decoder
    // must treat it as a plain flush, so the stimulus uses it too.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RESET_CYCLES   = 5;
    localparam int IDLE_PERCENT   = 23;
    localparam int RANDOM_ITEMS   = 1050;
    // Neither side idles inside this window of cycles.
    localparam int QUIET_FROM     = 400;
    localparam int QUIET_TO       = 900;
    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles allowed for stray results after the last expected unit.
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        t_in_item item;
        bit       drain;    // hold this item until every expected unit is out
    } t_pending_item;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_data   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       i_out_stall = 1'b0;

    t_pending_item pending_items[$];
    t_out_item     expected_units[$];
    t_out_item     step_units[$];
    t_out_item     oldest_unit;

    int fail_count  = 0;
    int cycle_count = 0;
    int idle_cycles = 0;

    // Decoder state as predicted by the testbench.
    t_seq_state  dec_state;
    logic [7:0]  dec_lead;
    logic [7:0]  dec_second;
    logic [7:0]  dec_third;
    logic [2:0]  dec_skip;

    utf8_to_utf16_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction of the code units each accepted item produces.
    // ------------------------------------------------------------------

    function automatic bit is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // An item never yields more than two units; anything past that is dropped.
    task automatic emit_unit(input logic [15:0] unit, input logic rep);
        t_out_item u;
        if (step_units.size() < 2) begin
            u.code_unit = unit;
            u.replaced  = rep;
            u.last      = 1'b0;
            step_units.push_back(u);
        end
    endtask

    // A byte seen while no sequence is open: either a lead byte that opens
    // a form, a plain ASCII unit, or something that is replaced at once.
    task automatic begin_sequence(input logic [7:0] b);
        if (b[7:4] == 4'hC || b[7:4] == 4'hD) begin
            dec_lead  = b;
            dec_state = ST_TWO_2;
        end else if (b[7:4] == 4'hE) begin
            dec_lead  = b;
            dec_state = ST_THREE_2;
        end else if (b[7:4] == 4'hF) begin
            if (b[3:0] < 4'h8) begin
                dec_lead  = b;
                dec_state = ST_FOUR_2;
            end else if (b[3:0] < 4'hE) begin
                // Five-byte leads skip four continuations, six-byte leads five.
                dec_skip  = (b[3:0] >= 4'hC) ? 3'd5 : 3'd4;
                dec_state = ST_SKIP;
            end else begin
                emit_unit(REPL_UNIT, 1'b1);
            end
        end else if (b > 8'h7F) begin
            emit_unit(REPL_UNIT, 1'b1);
        end else begin
            emit_unit({8'h00, b}, 1'b0);
        end
    endtask

    // A non-continuation byte inside an open form closes it with a
    // replacement, and the byte is then decoded as if the decoder were idle.
    task automatic break_sequence(input logic [7:0] b);
        dec_state = ST_IDLE;
        emit_unit(REPL_UNIT, 1'b1);
        begin_sequence(b);
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [20:0] cp;
        logic [19:0] offset;
        case (dec_state)
            ST_TWO_2: begin
                if (!is_cont(b)) begin
                    break_sequence(b);
                end else begin
                    dec_state = ST_IDLE;
                    cp = {10'd0, dec_lead[4:0], b[5:0]};
                    if (cp < 21'h00080) emit_unit(REPL_UNIT, 1'b1);
                    else emit_unit(cp[15:0], 1'b0);
                end
            end
            ST_THREE_2: begin
                if (!is_cont(b)) begin
                    break_sequence(b);
                end else begin
                    dec_second = b;
                    dec_state  = ST_THREE_3;
                end
            end
            ST_THREE_3: begin
                if (!is_cont(b)) begin
                    break_sequence(b);
                end else begin
                    dec_state = ST_IDLE;
                    cp = {5'd0, dec_lead[3:0], dec_second[5:0], b[5:0]};
                    if (cp < 21'h00800 || (cp >= 21'h0D800 && cp <= 21'h0DFFF) ||
                            cp >= 21'h0FFFE) begin
                        emit_unit(REPL_UNIT, 1'b1);
                    end else begin
                        emit_unit(cp[15:0], 1'b0);
                    end
                end
            end
            ST_FOUR_2: begin
                if (!is_cont(b)) begin
                    break_sequence(b);
                end else begin
                    dec_second = b;
                    dec_state  = ST_FOUR_3;
                end
            end
            ST_FOUR_3: begin
                if (!is_cont(b)) begin
                    break_sequence(b);
                end else begin
                    dec_third = b;
                    dec_state = ST_FOUR_4;
                end
            end
            ST_FOUR_4: begin
                if (!is_cont(b)) begin
                    break_sequence(b);
                end else begin
                    dec_state = ST_IDLE;
                    cp = {dec_lead[2:0], dec_second[5:0], dec_third[5:0], b[5:0]};
                    if (cp > 21'h0FFFF && cp < 21'h10FFFE &&
                            cp != 21'h1FFFE && cp != 21'h1FFFF) begin
                        // Supplementary plane: high surrogate first.
                        offset = 20'(cp - 21'h10000);
                        emit_unit(16'hD800 | {6'd0, offset[19:10]}, 1'b0);
                        emit_unit(16'hDC00 | {6'd0, offset[9:0]}, 1'b0);
                    end else begin
                        emit_unit(REPL_UNIT, 1'b1);
                    end
                end
            end
            ST_SKIP: begin
                if (!is_cont(b)) begin
                    break_sequence(b);
                end else if (dec_skip <= 3'd1) begin
                    dec_state = ST_IDLE;
                    emit_unit(REPL_UNIT, 1'b1);
                end else begin
                    dec_skip = dec_skip - 3'd1;
                end
            end
            default: begin
                begin_sequence(b);
            end
        endcase
    endtask

    // Works out the units of one accepted item and queues them in order.
    task automatic predict_units(input t_in_item it);
        step_units.delete();
        // Both flush-only codes have the upper op bit set and take no byte.
        if (it.op[1] == 1'b0) take_byte(it.byte_in);
        if (it.op != OP_DATA && dec_state != ST_IDLE) begin
            emit_unit(REPL_UNIT, 1'b1);
            dec_state = ST_IDLE;
        end
        if (step_units.size() > 0) step_units[step_units.size() - 1].last = 1'b1;
        foreach (step_units[i]) expected_units.push_back(step_units[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------

    task automatic push_item(input logic [1:0] op, input logic [7:0] b, input bit drain);
        t_pending_item p;
        p.item.op      = op;
        p.item.byte_in = b;
        p.drain        = drain;
        pending_items.push_back(p);
    endtask

    // Encodes a code point in the given number of bytes, overlong if the
    // length is more than the value needs, and queues the first keep bytes.
    // The last queued byte carries end_op, so a form can end in a flush.
    task automatic add_form(input logic [20:0] cp, input int nbytes, input int keep,
                            input logic [1:0] end_op, input bit drain);
        logic [7:0] seq [4];
        case (nbytes)
            1: begin
                seq[0] = {1'b0, cp[6:0]};
            end
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) begin
            push_item((i == keep - 1) ? end_op : OP_DATA, seq[i], drain && i == 0);
        end
    endtask

    function automatic logic [7:0] random_cont();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic logic [7:0] random_non_cont();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b[7:6] == 2'b10) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Values where the decoder changes its mind: length limits, the
    // surrogate block, the noncharacters and the top of the code space.
    function automatic logic [20:0] boundary_cp(input int idx);
        case (idx)
            0:       return 21'h00007F;
            1:       return 21'h000080;
            2:       return 21'h0007FF;
            3:       return 21'h000800;
            4:       return 21'h00D7FF;
            5:       return 21'h00D800;
            6:       return 21'h00DFFF;
            7:       return 21'h00E000;
            8:       return 21'h00FFFD;
            9:       return 21'h00FFFE;
            10:      return 21'h00FFFF;
            11:      return 21'h010000;
            12:      return 21'h01FFFE;
            13:      return 21'h01FFFF;
            14:      return 21'h020000;
            15:      return 21'h10FFFD;
            16:      return 21'h10FFFE;
            17:      return 21'h10FFFF;
            default: return 21'h1FFFFF;
        endcase
    endfunction

    function automatic logic [20:0] pick_code_point();
        if ($urandom_range(0, 1) == 0) begin
            return 21'(boundary_cp($urandom_range(0, 18)) + $urandom_range(0, 2) - 1);
        end
        case ($urandom_range(0, 4))
            0:       return 21'($urandom_range(21'h000000, 21'h00007F));
            1:       return 21'($urandom_range(21'h000080, 21'h0007FF));
            2:       return 21'($urandom_range(21'h000800, 21'h00FFFF));
            3:       return 21'($urandom_range(21'h010000, 21'h10FFFF));
            default: return 21'($urandom_range(21'h110000, 21'h1FFFFF));
        endcase
    endfunction

    function automatic int natural_length(input logic [20:0] cp);
        if (cp < 21'h000080) return 1;
        if (cp < 21'h000800) return 2;
        if (cp < 21'h010000) return 3;
        return 4;
    endfunction

    // One random stretch of input. Most of it is well-formed or nearly
    // well-formed UTF-8 so that the deeper states are reached often.
    task automatic add_random_sequence(input bit drain);
        int         kind;
        int         nbytes;
        int         nconts;
        logic [20:0] cp;
        logic [1:0] end_op;
        logic [7:0] lead;
        kind   = $urandom_range(0, 99);
        end_op = ($urandom_range(0, 99) < 8) ? OP_DATA_FLUSH : OP_DATA;
        if (kind < 15) begin
            add_form(21'($urandom_range(0, 127)), 1, 1, end_op, drain);
        end else if (kind < 60) begin
            cp     = pick_code_point();
            nbytes = natural_length(cp);
            // Now and then an overlong form of the same value.
            if (nbytes < 4 && $urandom_range(0, 99) < 15) nbytes = nbytes + 1;
            add_form(cp, nbytes, nbytes, end_op, drain);
        end else if (kind < 70) begin
            // A form cut short by a foreign byte or by a flush.
            cp     = pick_code_point();
            nbytes = $urandom_range(2, 4);
            add_form(cp, nbytes, $urandom_range(1, nbytes - 1), OP_DATA, drain);
            case ($urandom_range(0, 2))
                0:       push_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'b0);
                1:       push_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
                default: push_item(end_op, random_non_cont(), 1'b0);
            endcase
        end else if (kind < 78) begin
            // Five- and six-byte forms, sometimes broken early or followed
            // by one continuation too many.
            lead   = 8'($urandom_range(8'hF8, 8'hFD));
            nconts = (lead >= 8'hFC) ? 5 : 4;
            push_item(OP_DATA, lead, drain);
            if ($urandom_range(0, 99) < 20) begin
                nconts = $urandom_range(0, nconts - 1);
                for (int i = 0; i < nconts; i++) push_item(OP_DATA, random_cont(), 1'b0);
                push_item(end_op, random_non_cont(), 1'b0);
            end else begin
                for (int i = 0; i < nconts; i++) push_item(OP_DATA, random_cont(), 1'b0);
                if ($urandom_range(0, 3) == 0) push_item(OP_DATA, random_cont(), 1'b0);
            end
        end else if (kind < 90) begin
            push_item(OP_DATA, 8'($urandom_range(0, 255)), drain);
        end else if (kind < 95) begin
            push_item($urandom_range(0, 1) ? OP_FLUSH : OP_UNUSED,
                      8'($urandom_range(0, 255)), drain);
        end else if ($urandom_range(0, 1) == 0) begin
            push_item(OP_DATA, random_cont(), drain);
        end else begin
            push_item(OP_DATA, 8'hFE | 8'($urandom_range(0, 1)), drain);
        end
    endtask

    // Directed opening: plain ASCII at both ends, an overlong form, a
    // genuine U+FFFD, a surrogate, a surrogate pair, the first forbidden
    // value at the top, stray and never-valid bytes, a broken form whose
    // interrupting byte is decoded anew, flushes with and without an open
    // form, and a five-byte form that is skipped.
    task automatic add_directed();
        add_form(21'h000000, 1, 1, OP_DATA, 1'b0);
        add_form(21'h00007F, 1, 1, OP_DATA, 1'b0);
        add_form(21'h000000, 2, 2, OP_DATA, 1'b0);
        add_form(21'h00FFFD, 3, 3, OP_DATA, 1'b0);
        add_form(21'h00D800, 3, 3, OP_DATA, 1'b0);
        add_form(21'h010000, 4, 4, OP_DATA, 1'b0);
        add_form(21'h10FFFE, 4, 4, OP_DATA, 1'b0);
        push_item(OP_DATA, 8'h80, 1'b0);
        push_item(OP_DATA, 8'hFE, 1'b0);
        push_item(OP_DATA, 8'hFF, 1'b0);
        add_form(21'h0020AC, 3, 1, OP_DATA, 1'b0);
        push_item(OP_DATA, 8'h41, 1'b0);
        add_form(21'h0000C0, 2, 1, OP_DATA_FLUSH, 1'b0);
        push_item(OP_FLUSH, 8'hFF, 1'b0);
        push_item(OP_DATA, 8'hF8, 1'b0);
        for (int i = 0; i < 4; i++) push_item(OP_DATA, random_cont(), 1'b0);
        add_form(21'h000800, 3, 2, OP_DATA, 1'b0);
        push_item(OP_UNUSED, 8'h00, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Driver, monitor and watchdog.
    // ------------------------------------------------------------------

    // Random idling on both channels, switched off inside the quiet window.
    function automatic bit random_gap();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // The driver predicts each item at the edge that accepts it and then
    // decides what to present next. Valid and data only move when the
    // previous item was taken, so a stalled item is held unchanged. An item
    // marked for draining is held back until every expected unit has left.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            dec_state  = ST_IDLE;
            dec_lead   = '0;
            dec_second = '0;
            dec_third  = '0;
            dec_skip   = '0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_units(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && !random_gap() &&
                        !(pending_items[0].drain && expected_units.size() != 0)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front().item;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The monitor checks every accepted unit against the oldest expected
    // unit, field by field, and stalls the output at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected code unit %h", o_out_data.code_unit);
                    fail_count++;
                end else begin
                    oldest_unit = expected_units.pop_front();
                    if (o_out_data.code_unit !== oldest_unit.code_unit) begin
                        $error("code_unit: expected %h, actual %h",
                               oldest_unit.code_unit, o_out_data.code_unit);
                        fail_count++;
                    end
                    if (o_out_data.replaced !== oldest_unit.replaced) begin
                        $error("replaced: expected %b, actual %b",
                               oldest_unit.replaced, o_out_data.replaced);
                        fail_count++;
                    end
                    if (o_out_data.last !== oldest_unit.last) begin
                        $error("last: expected %b, actual %b",
                               oldest_unit.last, o_out_data.last);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= random_gap();
        end
    end

    // The watchdog ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Builds the whole stimulus up front, releases reset, and waits at the
    // falling edge, where every clocked block has settled, for the stimulus
    // and the expected units to run out.
    initial begin
        int random_start;
        add_directed();
        random_start = pending_items.size();
        // The first random stretch waits for the output to drain, and a few
        // later ones do the same at random.
        add_random_sequence(1'b1);
        while (pending_items.size() - random_start < RANDOM_ITEMS) begin
            add_random_sequence($urandom_range(0, 99) == 0);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(negedge i_clk);
        while (expected_units.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
